### sv/encoder_period_speed_meter_macros.svh
// Assertion macros used by the checker file of the speed meter.
`ifndef ENCODER_PERIOD_SPEED_METER_MACROS_SVH
`define ENCODER_PERIOD_SPEED_METER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define EPS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("speed meter check failed");

// Next-cycle implication, disabled during reset.
`define EPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("speed meter check failed");

`endif

### sv/eps_pkg.sv
// Package with widths, register indexes, reset values and types of the speed meter.
`timescale 1ns / 1ps
`default_nettype none
package eps_pkg;

  localparam int CAPTURE_W = 32;
  localparam int SCALE_W   = 16;
  localparam int TICK_W    = 8;
  localparam int SPEED_W   = 24;
  localparam int ROT_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  // Dividend is the product of the rate and the scale factor.
  localparam int DIVIDEND_W = CAPTURE_W + SCALE_W;
  localparam int DIV_STEPS  = DIVIDEND_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_PER_TICK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_LENGTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_ROT  = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [CAPTURE_W-1:0] RST_CLOCK_PER_TICK = 32'd166666;
  localparam logic [CAPTURE_W-1:0] RST_WRAP_LENGTH    = 32'd2500000;
  localparam logic [SCALE_W-1:0]   RST_SPEED_SCALE    = 16'd1944;
  localparam logic [TICK_W-1:0]    RST_TICKS_PER_ROT  = 8'd6;

  localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};

  // Event kinds on the input channel.
  localparam logic FUNC_CAPTURE  = 1'b0;
  localparam logic FUNC_ROLLOVER = 1'b1;

  // Status of the iterative divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage
`default_nettype wire

### sv/encoder_period_speed_meter.sv
// Top level of the encoder period speed meter: sequencer, state and output register.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  in      | input     | in_valid/in_ready  | func, capture_value
//  out     | output    | out_valid/out_ready| speed, rotations, stopped
//  cfg     | input     | cfg_write          | cfg_index, cfg_data
//
// A capture event passes from transfer through the period register, the multiply,
// the bit-serial divider and the post state to the output register. A rollover
// event goes straight to the post state. A new event is taken only in idle.
// Reset clears the sequencer and measurement state; the block is ready as soon as reset drops.
// A stalled result waits in the output register; the next event is taken
// meanwhile, and its result waits until the register is free.
`timescale 1ns / 1ps
`default_nettype none
module encoder_period_speed_meter
  import eps_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  func,
  input  wire logic [CAPTURE_W-1:0]  capture_value,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [SPEED_W-1:0]    speed,
  output logic      [ROT_W-1:0]      rotations,
  output logic                       stopped
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_POST = 2'd3;

  logic [1:0]            state;

  logic [CAPTURE_W-1:0]  clock_per_tick_rate;
  logic [CAPTURE_W-1:0]  wrap_length;
  logic [SCALE_W-1:0]    speed_scale;
  logic [TICK_W-1:0]     ticks_per_rotation;

  logic [CAPTURE_W-1:0]  previous_capture;
  logic [1:0]            rollover_run;
  logic [TICK_W-1:0]     tick_index;
  logic [ROT_W-1:0]      rotation_total;
  logic [SPEED_W-1:0]    speed_value;
  logic [CAPTURE_W-1:0]  period;

  logic                  in_xfer;
  logic                  out_free;
  logic [CAPTURE_W-1:0]  period_next;
  logic [TICK_W:0]       tick_sum;
  logic [1:0]            run_next;
  logic [DIVIDEND_W-1:0] product;
  logic [DIVIDEND_W-1:0] quotient;
  logic [SPEED_W-1:0]    speed_next;
  logic                  div_start;
  div_status_t           div_status;

  assign in_ready = (state == S_IDLE) & ~rst;
  assign in_xfer  = in_valid & in_ready;
  assign out_free = ~out_valid | out_ready;

  // Period since the last capture; a count that did not rise has wrapped.
  assign period_next = (capture_value > previous_capture)
                     ? capture_value - previous_capture
                     : wrap_length + capture_value - previous_capture;

  assign tick_sum = {1'b0, tick_index} + 1'b1;
  assign run_next = (rollover_run == 2'd3) ? rollover_run : rollover_run + 1'b1;

  // The single multiplier feeds the divider's dividend register.
  assign product   = DIVIDEND_W'(clock_per_tick_rate) * DIVIDEND_W'(speed_scale);
  assign div_start = (state == S_MUL);

  eps_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (product),
    .divisor  (period),
    .status   (div_status),
    .quotient (quotient)
  );

  // Saturate the quotient to the speed width.
  assign speed_next = (|quotient[DIVIDEND_W-1:SPEED_W]) ? SPEED_MAX
                                                       : quotient[SPEED_W-1:0];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_per_tick_rate <= RST_CLOCK_PER_TICK;
      wrap_length         <= RST_WRAP_LENGTH;
      speed_scale         <= RST_SPEED_SCALE;
      ticks_per_rotation  <= RST_TICKS_PER_ROT;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CLOCK_PER_TICK: clock_per_tick_rate <= cfg_data;
        REG_WRAP_LENGTH:    wrap_length         <= cfg_data;
        REG_SPEED_SCALE:    speed_scale         <= cfg_data[SCALE_W-1:0];
        REG_TICKS_PER_ROT:  ticks_per_rotation  <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and measurement state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      previous_capture <= '0;
      rollover_run     <= '0;
      tick_index       <= '0;
      rotation_total   <= '0;
      speed_value      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (func == FUNC_CAPTURE) begin
              previous_capture <= capture_value;
              rollover_run     <= '0;
              if (tick_sum >= {1'b0, ticks_per_rotation}) begin
                tick_index     <= '0;
                rotation_total <= rotation_total + 1'b1;
              end else begin
                tick_index <= tick_sum[TICK_W-1:0];
              end
              state <= S_MUL;
            end else begin
              rollover_run <= run_next;
              if (run_next[1]) begin
                speed_value <= '0;
              end
              state <= S_POST;
            end
          end
        end
        S_MUL: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_status.done) begin
            speed_value <= speed_next;
            state       <= S_POST;
          end
        end
        S_POST: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Period register for the divider.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      period <= period_next;
    end
  end

  // Output register: loaded once the slot is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_POST && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_POST && out_free) begin
      speed     <= speed_value;
      rotations <= rotation_total;
      stopped   <= rollover_run[1];
    end
  end

endmodule
`default_nettype wire

### sv/eps_divider.sv
// Restoring shift-subtract divider that resolves one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module eps_divider
  import eps_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [CAPTURE_W-1:0]  divisor,
  output div_status_t                status,
  output logic      [DIVIDEND_W-1:0] quotient
);

  logic                  busy;
  logic                  done;
  logic [DIV_CNT_W-1:0]  count;
  logic [DIVIDEND_W-1:0] num;
  logic [CAPTURE_W-1:0]  rem;
  logic [CAPTURE_W-1:0]  div;

  logic [CAPTURE_W:0]    rem_sh;
  logic [CAPTURE_W+1:0]  diff;
  logic                  fits;

  // Shared subtractor: bring down the next dividend bit and try the divisor.
  assign rem_sh = {rem, num[DIVIDEND_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, div};
  assign fits   = ~diff[CAPTURE_W+1];

  // Control of the iteration count. A zero divisor yields an all-ones quotient.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient bits shift in as dividend bits shift out.
  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      rem <= '0;
      div <= divisor;
    end else if (busy) begin
      num <= {num[DIVIDEND_W-2:0], fits};
      rem <= fits ? diff[CAPTURE_W-1:0] : rem_sh[CAPTURE_W-1:0];
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quotient    = num;

endmodule
`default_nettype wire

### sv/eps_checker.sv
// Port-level checker for the speed meter and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "encoder_period_speed_meter_macros.svh"
module eps_checker
  import eps_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [SPEED_W-1:0] speed,
  input wire logic [ROT_W-1:0]   rotations,
  input wire logic               stopped
);

  // One event at a time: after a transfer the block is busy.
  `EPS_ASSERT_NEXT(a_busy_after_xfer, clk, rst, in_valid && in_ready, !in_ready)

  // A stopped wheel always reports zero speed.
  `EPS_ASSERT_NOW(a_stopped_zero, clk, rst, out_valid && stopped, speed == '0)

  // A stalled result stays offered.
  `EPS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)

  // A stalled result keeps its payload.
  `EPS_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready,
                   $stable(speed) && $stable(rotations) && $stable(stopped))

endmodule

bind encoder_period_speed_meter eps_checker u_eps_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .speed     (speed),
  .rotations (rotations),
  .stopped   (stopped)
);
`default_nettype wire
